[src/e2c_pkg.sv]
// Shared types, constants and a helper function for the epoch seconds to calendar block.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package e2c_pkg;

  localparam int unsigned SecsWidth  = 32;
  localparam int unsigned DaysWidth  = 16;
  localparam int unsigned TodWidth   = 17;
  localparam int unsigned YearWidth  = 12;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
  localparam logic [DaysWidth-1:0] DAYS_LIMIT   = 16'd47482;
  localparam logic [YearWidth-1:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [2:0]           EPOCH_WDAY   = 3'd4;
  localparam logic [3:0]           LAST_MONTH   = 4'd11;

  // Reciprocals: floor(x / d) is (x * RECIP) >> shift over each dividend's full range.
  // Days: (secs >> 7) * ceil(2^35 / 675) >> 35, since 86400 = 128 * 675.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // Weeks: days * ceil(2^19 / 7) >> 19.
  localparam logic [16:0] WEEK_RECIP = 17'd74899;
  // Hours: (tod >> 4) * ceil(2^21 / 225) >> 21, since 3600 = 16 * 225.
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  // Minutes: (rem >> 2) * ceil(2^14 / 15) >> 14, since 60 = 4 * 15.
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  // Which constant division the reciprocal unit runs.
  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_WEEK,
    DSEL_HOUR,
    DSEL_MIN
  } div_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     div_step;
    logic     div_save;
    div_sel_t div_sel;
    logic     cal_init;
    logic     year_step;
    logic     month_step;
    logic     out_load;
    logic     out_err;
  } e2c_cmd_t;

  typedef struct packed {
    logic day_over;
    logic year_done;
    logic month_done;
  } e2c_sts_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        range_error;
  } e2c_out_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] n;
    case (mon)
      4'd0:    n = 5'd31;
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd30;
      4'd4:    n = 5'd31;
      4'd5:    n = 5'd30;
      4'd6:    n = 5'd31;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd30;
      4'd9:    n = 5'd31;
      4'd10:   n = 5'd30;
      4'd11:   n = 5'd31;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[src/e2c_if.sv]
// Valid/ready channel interfaces for the seconds word and the calendar result word.
// Depends on e2c_pkg for field widths.
`timescale 1ns / 1ps

interface e2c_in_if;
  logic        valid;
  logic        ready;
  logic [e2c_pkg::SecsWidth-1:0] seconds_count;

  modport source (output valid, output seconds_count, input ready);
  modport sink   (input valid, input seconds_count, output ready);
endinterface

interface e2c_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic        range_error;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  output range_error, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  input range_error, output ready);
endinterface

[src/e2c_dp.sv]
// Datapath: reciprocal-multiply divisions, year/month subtraction and the result register.
// Depends on e2c_pkg; driven by commands from e2c_ctrl.
`timescale 1ns / 1ps

module e2c_dp (
  input  logic                               clk,
  input  logic [e2c_pkg::SecsWidth-1:0]      in_seconds_count,
  input  e2c_pkg::e2c_cmd_t                  cmd,
  output e2c_pkg::e2c_sts_t                  sts,
  output e2c_pkg::e2c_out_t                  out_word
);
  import e2c_pkg::*;

  logic [SecsWidth-1:0] secs_r;
  logic [DaysWidth-1:0] quo_r;
  logic [DaysWidth-1:0] days_r;
  logic [TodWidth-1:0]  tod_r;
  logic [11:0]          hrem_r;
  logic [2:0]           wday_r;
  logic [4:0]           hour_r;
  logic [5:0]           min_r;
  logic [5:0]           sec_r;
  logic [DaysWidth-1:0] rdays_r;
  logic [YearWidth-1:0] year_r;
  logic [3:0]           mon_r;
  e2c_out_t             out_r;

  logic [50:0]          day_prod;
  logic [32:0]          week_prod;
  logic [26:0]          hour_prod;
  logic [20:0]          min_prod;
  logic [DaysWidth-1:0] quo_nxt;
  logic [TodWidth-1:0]  tod_nxt;
  logic [2:0]           wk_rem;
  logic [3:0]           wk_sum;
  logic [3:0]           wk_wrap;
  logic [2:0]           wday_nxt;
  logic [11:0]          hrem_nxt;
  logic [5:0]           sec_nxt;
  logic                 leap;
  logic [8:0]           ylen;
  logic [4:0]           mlen;

  assign day_prod  = {26'd0, secs_r[SecsWidth-1:7]} * {25'd0, DAY_RECIP};
  assign week_prod = {17'd0, days_r} * {16'd0, WEEK_RECIP};
  assign hour_prod = {14'd0, tod_r[16:4]} * {13'd0, HOUR_RECIP};
  assign min_prod  = {11'd0, hrem_r[11:2]} * {10'd0, MIN_RECIP};

  always_comb begin
    case (cmd.div_sel)
      DSEL_DAY:  quo_nxt = day_prod[50:35];
      DSEL_WEEK: quo_nxt = {2'd0, week_prod[32:19]};
      DSEL_HOUR: quo_nxt = {10'd0, hour_prod[26:21]};
      DSEL_MIN:  quo_nxt = {9'd0, min_prod[20:14]};
      default:   quo_nxt = day_prod[50:35];
    endcase
  end

  // Each remainder is below its field's range, so the low bits of the difference are exact.
  assign tod_nxt  = secs_r[TodWidth-1:0] - {1'b0, quo_r} * SECS_PER_DAY;
  assign wk_rem   = days_r[2:0] - quo_r[2:0] * DAYS_PER_WEEK;
  assign wk_sum   = {1'b0, wk_rem} + {1'b0, EPOCH_WDAY};
  assign wk_wrap  = wk_sum - {1'b0, DAYS_PER_WEEK};
  assign wday_nxt = (wk_sum >= {1'b0, DAYS_PER_WEEK}) ? wk_wrap[2:0] : wk_sum[2:0];
  assign hrem_nxt = tod_r[11:0] - quo_r[11:0] * SECS_PER_HOUR;
  assign sec_nxt  = hrem_r[5:0] - quo_r[5:0] * SECS_PER_MIN;

  // Years stay within 1970..2099, so the 100/400 exceptions reduce to 2000 being leap.
  assign leap = (year_r[1:0] == 2'b00);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_r, leap);

  assign sts.day_over   = days_r >= DAYS_LIMIT;
  assign sts.year_done  = rdays_r < {7'd0, ylen};
  assign sts.month_done = (mon_r == LAST_MONTH) || (rdays_r < {11'd0, mlen});

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      secs_r <= in_seconds_count;
    end

    if (cmd.div_step) begin
      quo_r <= quo_nxt;
    end

    if (cmd.div_save) begin
      case (cmd.div_sel)
        DSEL_DAY: begin
          days_r <= quo_r;
          tod_r  <= tod_nxt;
        end
        DSEL_WEEK: wday_r <= wday_nxt;
        DSEL_HOUR: begin
          hour_r <= quo_r[4:0];
          hrem_r <= hrem_nxt;
        end
        DSEL_MIN: begin
          min_r <= quo_r[5:0];
          sec_r <= sec_nxt;
        end
        default: ;
      endcase
    end

    if (cmd.cal_init) begin
      rdays_r <= days_r;
      year_r  <= EPOCH_YEAR;
      mon_r   <= '0;
    end else if (cmd.year_step) begin
      rdays_r <= rdays_r - {7'd0, ylen};
      year_r  <= year_r + 12'd1;
    end else if (cmd.month_step) begin
      rdays_r <= rdays_r - {11'd0, mlen};
      mon_r   <= mon_r + 4'd1;
    end

    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_r.year         <= '0;
        out_r.month        <= '0;
        out_r.day_of_month <= '0;
        out_r.hour         <= '0;
        out_r.minute       <= '0;
        out_r.second       <= '0;
        out_r.weekday      <= '0;
        out_r.range_error  <= 1'b1;
      end else begin
        out_r.year         <= year_r;
        out_r.month        <= mon_r + 4'd1;
        out_r.day_of_month <= rdays_r[4:0] + 5'd1;
        out_r.hour         <= hour_r;
        out_r.minute       <= min_r;
        out_r.second       <= sec_r;
        out_r.weekday      <= wday_r;
        out_r.range_error  <= 1'b0;
      end
    end
  end

  assign out_word = out_r;

endmodule

[src/e2c_ctrl.sv]
// Controller: sequences the constant divisions, the year and month loops and the result handoff.
// Depends on e2c_pkg; commands e2c_dp.
`timescale 1ns / 1ps

module e2c_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  e2c_pkg::e2c_sts_t  sts,
  output e2c_pkg::e2c_cmd_t  cmd
);
  import e2c_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SAVE,
    S_CHECK,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  div_sel_t            sel_r, sel_nxt;
  logic                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    cmd.out_err   = err_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          sel_nxt     = DSEL_DAY;
          err_nxt     = 1'b0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_SAVE;
      end
      S_SAVE: begin
        cmd.div_save = 1'b1;
        case (sel_r)
          DSEL_DAY: state_nxt = S_CHECK;
          DSEL_WEEK: begin
            sel_nxt   = DSEL_HOUR;
            state_nxt = S_DIV;
          end
          DSEL_HOUR: begin
            sel_nxt   = DSEL_MIN;
            state_nxt = S_DIV;
          end
          DSEL_MIN: begin
            cmd.cal_init = 1'b1;
            state_nxt    = S_YEAR;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHECK: begin
        if (sts.day_over) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          sel_nxt   = DSEL_WEEK;
          state_nxt = S_DIV;
        end
      end
      S_YEAR: begin
        if (sts.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts.month_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DONE: begin
        // Hold until the result register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= DSEL_DAY;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/epoch_seconds_to_calendar_top.sv]
// Epoch seconds to calendar converter.
// Input channel in_ch carries a 32-bit seconds count since 1970-01-01 00:00:00;
// output channel out_ch returns one word per input: year, month, day_of_month,
// hour, minute, second, weekday (0 is Sunday) and range_error.
// Both channels use valid/ready; a word moves when both are high at a clock edge.
// One word is worked on at a time. The day, weekday, hour and minute divisions
// each run a reciprocal multiply step and then a remainder step, then the year
// loop subtracts one year per cycle and the month loop one month per cycle. A
// count past 2099-12-31 23:59:59 skips the other steps and returns with
// range_error set and all other fields zero. in_ch.ready rises again in the same
// cycle that out_ch.valid rises with the registered result, so the next word is
// taken while the result waits.
// If the receiver stalls, the result holds in the output register and a
// finished next word waits until that register empties.
// Synchronous active-low reset returns to idle and drops any pending result.
// Depends on e2c_pkg, e2c_if, e2c_ctrl and e2c_dp.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top (
  input  logic         clk,
  input  logic         rst_n,
  e2c_in_if.sink       in_ch,
  e2c_out_if.source    out_ch
);
  import e2c_pkg::*;

  e2c_cmd_t cmd;
  e2c_sts_t sts;
  e2c_out_t out_word;

  e2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  e2c_dp u_dp (
    .clk              (clk),
    .in_seconds_count (in_ch.seconds_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_word         (out_word)
  );

  assign out_ch.year         = out_word.year;
  assign out_ch.month        = out_word.month;
  assign out_ch.day_of_month = out_word.day_of_month;
  assign out_ch.hour         = out_word.hour;
  assign out_ch.minute       = out_word.minute;
  assign out_ch.second       = out_word.second;
  assign out_ch.weekday      = out_word.weekday;
  assign out_ch.range_error  = out_word.range_error;

endmodule
